// ===== sv/vnf_pkg.sv =====
package vnf_pkg;

  localparam int COORD_W = 48;
  localparam int CELL_LAT = 10;
  localparam int DIV_STAGES = 16;

  localparam logic [31:0] MUL_X = 32'h27d4eb2d;
  localparam logic [31:0] MUL_Z = 32'h165667b1;
  localparam logic [31:0] MUL_F = 32'h9e3779b1;
  localparam logic [31:0] HASH_MOD = 32'd100000;
  localparam logic [17:0] THREE_Q16 = 18'd196608;
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  // ceil(2^49 / 100000): exact quotient of any 32-bit value by 100000 after >> 49.
  localparam logic [32:0] RECIP_H = 33'd5629499535;
  // ceil(2^50 / 100000): exact quotient of (r << 16) by 100000 after >> 34.
  localparam logic [33:0] RECIP_R = 34'd11258999069;

  typedef logic [31:0] word_t;

  function automatic word_t hash_mix(input word_t mx, input word_t mz);
    word_t h;
    h = mx ^ (mx >> 15);
    h = h + mz;
    h = h ^ (h >> 13);
    return h;
  endfunction

endpackage

// ===== sv/vnf_cell.sv =====
module vnf_cell
  import vnf_pkg::*;
#(
  parameter int IDX = 0,
  parameter int NW = 4,
  parameter int ACC_W = 24
) (
  input  logic               clk,
  input  logic               en,
  input  logic [NW-1:0]      n_eff,
  input  logic [COORD_W-1:0] cx_i,
  input  logic [COORD_W-1:0] cz_i,
  input  logic [ACC_W-1:0]   acc_i,
  output logic [COORD_W-1:0] cx_o,
  output logic [COORD_W-1:0] cz_o,
  output logic [ACC_W-1:0]   acc_o
);

  logic [COORD_W-1:0] cx_dly [CELL_LAT];
  logic [COORD_W-1:0] cz_dly [CELL_LAT];
  logic [ACC_W-1:0]   acc_dly [CELL_LAT-1];

  logic [31:0] mxa, mxb, mza, mzb;
  logic [31:0] fx2, fz2;
  logic [15:0] fx1, fz1;
  logic [49:0] px, pz;
  logic [15:0] wx [5];
  logic [15:0] wz [6];
  logic [31:0] h2 [4];
  logic [31:0] h3 [4];
  logic [31:0] h4 [4];
  logic [64:0] p4 [4];
  logic [16:0] r5 [4];
  logic [50:0] p6 [4];
  logic [15:0] v7 [4];
  logic [15:0] ab, cd;
  logic [15:0] oct;
  logic        active;

  assign active = NW'(IDX) < n_eff;

  always_ff @(posedge clk) begin
    if (en) begin
      cx_dly[0] <= cx_i;
      cz_dly[0] <= cz_i;
      acc_dly[0] <= acc_i;
      for (int s = 1; s < CELL_LAT; s++) begin
        cx_dly[s] <= cx_dly[s-1];
        cz_dly[s] <= cz_dly[s-1];
      end
      for (int s = 1; s < CELL_LAT - 1; s++) begin
        acc_dly[s] <= acc_dly[s-1];
      end

      // Lattice multiplies and fraction squares.
      mxa <= cx_i[47:16] * MUL_X;
      mxb <= (cx_i[47:16] + 32'd1) * MUL_X;
      mza <= cz_i[47:16] * MUL_Z;
      mzb <= (cz_i[47:16] + 32'd1) * MUL_Z;
      fx2 <= 32'(cx_i[15:0]) * 32'(cx_i[15:0]);
      fz2 <= 32'(cz_i[15:0]) * 32'(cz_i[15:0]);
      fx1 <= cx_i[15:0];
      fz1 <= cz_i[15:0];

      // Corners in the order (x0,z0), (x1,z0), (x0,z1), (x1,z1).
      h2[0] <= hash_mix(mxa, mza);
      h2[1] <= hash_mix(mxb, mza);
      h2[2] <= hash_mix(mxa, mzb);
      h2[3] <= hash_mix(mxb, mzb);
      px <= 50'(fx2) * 50'(THREE_Q16 - 18'({fx1, 1'b0}));
      pz <= 50'(fz2) * 50'(THREE_Q16 - 18'({fz1, 1'b0}));

      wx[0] <= px[47:32];
      wz[0] <= pz[47:32];
      for (int s = 1; s < 5; s++) wx[s] <= wx[s-1];
      for (int s = 1; s < 6; s++) wz[s] <= wz[s-1];

      for (int k = 0; k < 4; k++) begin
        h3[k] <= h2[k] * MUL_F;
        h4[k] <= h3[k] ^ (h3[k] >> 16);
        p4[k] <= 65'(h3[k] ^ (h3[k] >> 16)) * 65'(RECIP_H);
        r5[k] <= 17'(h4[k] - 32'(p4[k][64:49]) * HASH_MOD);
        p6[k] <= 51'(r5[k]) * 51'(RECIP_R);
        v7[k] <= p6[k][49:34];
      end

      ab <= 16'((33'(v7[0]) * 33'(ONE_Q16 - 17'(wx[4])) + 33'(v7[1]) * 33'(wx[4])) >> 16);
      cd <= 16'((33'(v7[2]) * 33'(ONE_Q16 - 17'(wx[4])) + 33'(v7[3]) * 33'(wx[4])) >> 16);
      oct <= 16'((33'(ab) * 33'(ONE_Q16 - 17'(wz[5])) + 33'(cd) * 33'(wz[5])) >> 16);

      // Horner form of the weighted sum: the earliest octave ends up with the top weight.
      if (active) begin
        acc_o <= {acc_dly[CELL_LAT-2][ACC_W-2:0], 1'b0} + ACC_W'(oct);
      end else begin
        acc_o <= acc_dly[CELL_LAT-2];
      end
    end
  end

  assign cx_o = {cx_dly[CELL_LAT-1][COORD_W-2:0], 1'b0};
  assign cz_o = {cz_dly[CELL_LAT-1][COORD_W-2:0], 1'b0};

endmodule

// ===== sv/vnf_div.sv =====
module vnf_div
  import vnf_pkg::*;
#(
  parameter int D_W = 8,
  parameter int ACC_W = 24
) (
  input  logic             clk,
  input  logic             en,
  input  logic [ACC_W-1:0] dividend,
  input  logic [D_W-1:0]   divisor,
  output logic [15:0]      quotient
);

  logic [D_W-1:0] rem [DIV_STAGES+1];
  logic [15:0]    low [DIV_STAGES+1];
  logic [15:0]    quo [DIV_STAGES+1];

  // The quotient always fits 16 bits, so the top part is already below the divisor.
  assign rem[0] = dividend[ACC_W-1:16];
  assign low[0] = dividend[15:0];
  assign quo[0] = '0;

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
    logic [D_W:0] trial;
    logic         fits;
    assign trial = {rem[j], low[j][15]};
    assign fits = trial >= {1'b0, divisor};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1] <= fits ? D_W'(trial - {1'b0, divisor}) : D_W'(trial);
        low[j+1] <= {low[j][14:0], 1'b0};
        quo[j+1] <= {quo[j][14:0], fits};
      end
    end
  end

  assign quotient = quo[DIV_STAGES];

endmodule

// ===== sv/value_noise_fbm_2d_core.sv =====
// Throughput: one transaction per cycle while the output is not stalled; one cell per octave,
// ten stages deep, then a sixteen-stage restoring divider.
// The whole pipeline advances when the output register is empty or being taken.
// Reset (rst, synchronous) empties the pipeline and sets octave_count to 3.
module value_noise_fbm_2d_core
  import vnf_pkg::*;
#(
  parameter int MAX_OCTAVES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // coord_x [31:0], coord_z [63:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // noise_value [15:0]
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata
);

  localparam int NW = $clog2(MAX_OCTAVES + 1);
  localparam int ACC_W = 16 + MAX_OCTAVES;
  localparam int LAT = CELL_LAT * MAX_OCTAVES + DIV_STAGES;

  logic [3:0]         octave_count;
  logic [NW-1:0]      n_eff;
  logic [MAX_OCTAVES:0] div_full;
  logic [MAX_OCTAVES-1:0] divisor;
  logic               en;
  logic [LAT-1:0]     vld;

  logic [COORD_W-1:0] cx [MAX_OCTAVES+1];
  logic [COORD_W-1:0] cz [MAX_OCTAVES+1];
  logic [ACC_W-1:0]   acc [MAX_OCTAVES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      octave_count <= 4'd3;
    end else if (cfg_we) begin
      octave_count <= cfg_wdata;
    end
  end

  always_comb begin
    if (octave_count == 4'd0) begin
      n_eff = NW'(1);
    end else if (32'(octave_count) > MAX_OCTAVES) begin
      n_eff = NW'(MAX_OCTAVES);
    end else begin
      n_eff = NW'(octave_count);
    end
    div_full = ((MAX_OCTAVES + 1)'(1) << n_eff) - (MAX_OCTAVES + 1)'(1);
    divisor = div_full[MAX_OCTAVES-1:0];
  end

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  assign m_tvalid = vld[LAT-1];

  assign cx[0] = {{(COORD_W - 32){s_tdata[31]}}, s_tdata[31:0]};
  assign cz[0] = {{(COORD_W - 32){s_tdata[63]}}, s_tdata[63:32]};
  assign acc[0] = '0;

  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_cell
    vnf_cell #(
      .IDX(i),
      .NW(NW),
      .ACC_W(ACC_W)
    ) u_cell (
      .clk(clk),
      .en(en),
      .n_eff(n_eff),
      .cx_i(cx[i]),
      .cz_i(cz[i]),
      .acc_i(acc[i]),
      .cx_o(cx[i+1]),
      .cz_o(cz[i+1]),
      .acc_o(acc[i+1])
    );
  end

  vnf_div #(
    .D_W(MAX_OCTAVES),
    .ACC_W(ACC_W)
  ) u_div (
    .clk(clk),
    .en(en),
    .dividend(acc[MAX_OCTAVES]),
    .divisor(divisor),
    .quotient(m_tdata)
  );

endmodule

// ===== sv/vnf_checker.sv =====
module vnf_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // Reset leaves no transaction in flight.
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result presented straight after reset");

  // A stalled result stays and keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // The input side only stalls while a result is waiting.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output stall");

endmodule

bind value_noise_fbm_2d_core vnf_checker u_chk (.*);

// ===== tb/sv/vnf_checker.sv =====
`timescale 1ns / 1ps

module tb_vnf_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  output int          fail_count,
  output int          pending
);

  logic [3:0]  octaves;
  logic [15:0] noise_q[$];

  function automatic logic [31:0] corner_frac(input logic [31:0] xi, input logic [31:0] zi);
    logic [31:0] h;
    logic [63:0] t;
    h = xi * 32'h27d4eb2d;
    h = h ^ (h >> 15);
    h = h + zi * 32'h165667b1;
    h = h ^ (h >> 13);
    h = h * 32'h9e3779b1;
    h = h ^ (h >> 16);
    t = 64'(h % 32'd100000) * 64'd65536 / 64'd100000;
    return t[31:0];
  endfunction

  function automatic logic [31:0] smooth(input logic [15:0] f);
    logic [63:0] f2;
    logic [63:0] t;
    f2 = 64'(f) * 64'(f);
    t = 64'd196608 - 64'd2 * 64'(f);
    t = (f2 * t) >> 32;
    return t[31:0];
  endfunction

  function automatic logic [31:0] blend(input logic [31:0] a, input logic [31:0] b,
                                        input logic [31:0] w);
    logic [63:0] v;
    v = 64'(a) * (64'd65536 - 64'(w)) + 64'(b) * 64'(w);
    return v[47:16];
  endfunction

  function automatic logic [15:0] fbm_noise(input logic [31:0] px, input logic [31:0] pz,
                                            input logic [3:0] oc);
    logic [63:0] cx, cz, sx, sz, sum, norm;
    logic [31:0] x0, z0, wx, wz, ab, cd;
    int n;
    cx = {{32{px[31]}}, px};
    cz = {{32{pz[31]}}, pz};
    n = (oc < 1) ? 1 : (oc > 8) ? 8 : oc;
    sum = 0;
    for (int i = 0; i < n; i++) begin
      sx = cx << i;
      sz = cz << i;
      x0 = sx[47:16];
      z0 = sz[47:16];
      wx = smooth(sx[15:0]);
      wz = smooth(sz[15:0]);
      ab = blend(corner_frac(x0, z0), corner_frac(x0 + 1, z0), wx);
      cd = blend(corner_frac(x0, z0 + 1), corner_frac(x0 + 1, z0 + 1), wx);
      sum += 64'(blend(ab, cd, wz)) << (n - 1 - i);
    end
    norm = (64'd1 << n) - 1;
    sum = sum / norm;
    return sum[15:0];
  endfunction

  always @(posedge clk) begin
    logic [15:0] want;
    if (rst) begin
      octaves <= 4'd3;
      fail_count <= 0;
      pending <= 0;
      noise_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (noise_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $realtime, m_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = noise_q.pop_front();
          if (want !== m_tdata) begin
            $display("%0t: noise_value mismatch, expected %h, actual %h",
                     $realtime, want, m_tdata);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (s_tvalid && s_tready)
        noise_q.push_back(fbm_noise(s_tdata[31:0], s_tdata[63:32], octaves));
      if (cfg_we)
        octaves <= cfg_wdata;
      pending <= noise_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_value_noise_fbm_2d_core.sv =====
`timescale 1ns / 1ps

module tb_value_noise_fbm_2d_core;

  localparam int LATENCY = 10 * 8 + 16;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;   // coord_x [31:0], coord_z [63:32]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // noise_value [15:0]
  logic        cfg_we = 1'b0;
  logic [3:0]  cfg_wdata = '0;
  int          fail_count;
  int          pending;
  bit          calm = 1'b0;

  always #1 clk = ~clk;

  value_noise_fbm_2d_core #(.MAX_OCTAVES(8)) uut (.*);

  tb_vnf_checker chk (.*);

  // Output back-pressure; no stalls while the stimulus runs its calm stretch.
  always @(negedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= 16);
  end

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(5))
      0: return 32'h8000_0000 + $urandom_range(3);
      1: return 32'h7fff_ffff - $urandom_range(3);
      2: return {16'($urandom_range(8) - 4), 16'($urandom)};
      3: return {$urandom_range(1) ? 16'h0000 : 16'hffff, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // Leaves tvalid high after the transaction so that points can follow back to back.
  task automatic send_point(input logic [31:0] px, input logic [31:0] pz);
    while (!calm && $urandom_range(99) < 16) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {pz, px};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_and_set(input logic [3:0] oc);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= oc;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [3:0] settings[7] = '{4'd0, 4'd1, 4'd8, 4'd15, 4'd5, 4'd2, 4'd10};
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // Directed points at the reset octave count: extremes, zero, wrap of the lattice.
    send_point(32'h0, 32'h0);
    send_point(32'h7fff_ffff, 32'h7fff_ffff);
    send_point(32'h8000_0000, 32'h8000_0000);
    send_point(32'hffff_ffff, 32'h0000_ffff);
    send_point(32'h7fff_0000, 32'h8000_ffff);
    send_point(32'h0000_8000, 32'hffff_8000);
    send_point(32'h5555_5555, 32'haaaa_aaaa);
    send_point(32'haaaa_aaaa, 32'h5555_5555);
    send_point(32'h0001_0000, 32'hffff_0000);
    send_point(32'h0000_0001, 32'hffff_fffe);
    for (int p = 0; p < 7; p++) begin
      drain_and_set(settings[p]);
      send_point(32'h7fff_ffff, 32'h8000_0000);
      send_point(32'hffff_ffff, 32'h0000_0000);
      for (int k = 0; k < 275; k++) begin
        calm = (k >= 100 && k < 150);
        send_point(pick_coord(), pick_coord());
      end
      calm = 1'b0;
    end
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
